FILE: hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;
  localparam int unsigned ArenaGranules = 4096;
  localparam int unsigned GW = $clog2(ArenaGranules);   // granule index width
  localparam int unsigned SW = GW + 1;                  // size / count width
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [0:0] REG_ARENA  = 1'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] request_bytes;
    logic [14:0] payload_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] granted_offset;
    logic [15:0] bytes_in_use;
    logic [15:0] high_water_bytes;
    logic [31:0] failure_count;
    logic [14:0] largest_free_bytes;
  } rsp_t;

  // header word: free mark and payload size in granules
  typedef struct packed {
    logic          free;
    logic [SW-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic          we;
    logic [GW-1:0] waddr;
    hdr_t          wdata;
    logic          re;
    logic [GW-1:0] raddr;
  } mem_cmd_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ffba_hdr_ram.sv
// ----------------------------------------------------------------------------
// ffba_hdr_ram
// Block header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_hdr_ram (
  input  wire logic              clk_i,
  input  wire ffba_pkg::mem_cmd_t cmd_i,
  output ffba_pkg::hdr_t         rdata_o
);
  ffba_pkg::hdr_t mem_q [ffba_pkg::ArenaGranules];

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) mem_q[cmd_i.waddr] <= cmd_i.wdata;
    if (cmd_i.re) rdata_o <= mem_q[cmd_i.raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ffba_walker.sv
// ----------------------------------------------------------------------------
// ffba_walker
// Sequencer that walks the block chain for allocate, free and query.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_walker (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire ffba_pkg::req_t         req_i,
  input  wire logic                   carve_i,
  input  wire logic [ffba_pkg::SW-1:0] arena_i,
  output logic                        busy_o,
  output logic                        valid_o,
  output ffba_pkg::rsp_t              rsp_o,
  output ffba_pkg::mem_cmd_t          cmd_o,
  input  wire ffba_pkg::hdr_t         rdata_i
);
  localparam int unsigned SW = ffba_pkg::SW;
  localparam int unsigned GW = ffba_pkg::GW;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;   // read issued for cur_q
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_MREAD = 3'd3;   // merge: read issued for next block
  localparam logic [2:0] S_MEVAL = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_q, state_d;
  ffba_pkg::req_t req_q;
  logic [SW-1:0] cur_q, cur_d, want_q, tgt_q, best_q, best_d, size_q, size_d;
  logic [15:0]   inuse_q, inuse_d, peak_q, peak_d;
  logic [31:0]   fail_q, fail_d;
  logic [1:0]    status_q, status_d;
  logic [14:0]   grant_q, grant_d;
  logic          init_q;  // entry zero not yet written after carve
  logic [SW-1:0] nxt;
  logic [16:0]   inc;
  logic [15:0]   dec;

  assign busy_o = (state_q != S_IDLE) || init_q;
  assign nxt = cur_q + {{(SW-1){1'b0}}, 1'b1} + rdata_i.size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q  <= 1'b1;
      inuse_q <= '0; peak_q <= '0; fail_q <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= carve_i ? S_IDLE : state_d;
      init_q  <= carve_i;
      inuse_q <= carve_i ? '0 : inuse_d;
      peak_q  <= carve_i ? '0 : peak_d;
      fail_q  <= carve_i ? '0 : fail_d;
      valid_o <= (state_q == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; best_q <= best_d; size_q <= size_d;
    status_q <= status_d; grant_q <= grant_d;
    if (start_i && !busy_o) begin
      req_q  <= req_i;
      // requests beyond the size field saturate, so they never fit
      want_q <= (req_i.request_bytes > 16'd65528) ? {SW{1'b1}} :
                SW'((17'(req_i.request_bytes) + 17'd7) >> 3);
      tgt_q  <= SW'((req_i.payload_offset >> 3) - 15'd1);
    end
  end

  always_comb begin
    state_d = state_q; cur_d = cur_q; best_d = best_q; size_d = size_q;
    inuse_d = inuse_q; peak_d = peak_q; fail_d = fail_q;
    status_d = status_q; grant_d = grant_q;
    cmd_o = '0;
    inc = 17'(inuse_q) + 17'({want_q + 1'b1, 3'b000});
    dec = inuse_q - 16'({size_q + 1'b1, 3'b000});
    if (init_q) begin
      cmd_o.we = 1'b1;
      cmd_o.wdata = '{free: 1'b1, size: arena_i - 1'b1};
    end
    unique case (state_q)
      S_IDLE: if (start_i && !busy_o) begin
        cur_d = '0; best_d = '0; grant_d = '0; status_d = ffba_pkg::ST_IGNORED;
        cmd_o.re = 1'b1;
        unique case (req_i.kind)
          ffba_pkg::KIND_ALLOC: state_d = (req_i.request_bytes != 16'd0) ? S_READ : S_DONE;
          ffba_pkg::KIND_FREE:
            state_d = (req_i.payload_offset[2:0] == 3'd0 &&
                       req_i.payload_offset[14:3] != 12'd0) ? S_READ : S_DONE;
          ffba_pkg::KIND_QUERY: state_d = S_READ;
          default: state_d = S_DONE;
        endcase
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        state_d = S_READ;
        cmd_o.re = 1'b1;
        cmd_o.raddr = GW'(nxt);
        cur_d = nxt;
        unique case (req_q.kind)
          ffba_pkg::KIND_ALLOC:
            if (rdata_i.free && rdata_i.size >= want_q) begin
              cmd_o.re = 1'b0;
              cmd_o.we = 1'b1;
              cmd_o.waddr = GW'(cur_q);
              if (rdata_i.size >= want_q + 2'd2) begin
                // split: write remainder now, shrunk header in S_DONE
                cmd_o.waddr = GW'(cur_q + want_q + 1'b1);
                cmd_o.wdata = '{free: 1'b1, size: rdata_i.size - want_q - 1'b1};
                size_d = want_q;
              end else begin
                cmd_o.wdata = '{free: 1'b0, size: rdata_i.size};
                size_d = rdata_i.size;
              end
              cur_d = cur_q;
              inc = 17'(inuse_q) + 17'({size_d + 1'b1, 3'b000});
              inuse_d = inc[15:0];
              if (inc[15:0] > peak_q) peak_d = inc[15:0];
              grant_d = 15'({cur_q + 1'b1, 3'b000});
              status_d = ffba_pkg::ST_DONE;
              state_d = S_DONE;
            end else if (nxt >= arena_i) begin
              fail_d = fail_q + 32'd1;
              status_d = ffba_pkg::ST_NOFIT;
              state_d = S_DONE;
            end
          ffba_pkg::KIND_FREE:
            if (cur_q == tgt_q) begin
              cur_d = cur_q;
              if (!rdata_i.free) begin
                size_d = rdata_i.size;
                inuse_d = inuse_q - 16'({rdata_i.size + 1'b1, 3'b000});
                status_d = ffba_pkg::ST_DONE;
                state_d = (nxt >= arena_i) ? S_DONE : S_MREAD;
                if (nxt >= arena_i) cmd_o.re = 1'b0;
              end else begin
                cmd_o.re = 1'b0;
                state_d = S_DONE;
              end
            end else if (nxt >= arena_i || nxt > tgt_q) begin
              cmd_o.re = 1'b0;
              state_d = S_DONE;
            end
          default: begin
            if (rdata_i.free && rdata_i.size > best_q) best_d = rdata_i.size;
            if (nxt >= arena_i) begin
              cmd_o.re = 1'b0;
              status_d = ffba_pkg::ST_DONE;
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_MREAD: state_d = S_MEVAL;
      S_MEVAL: begin
        // rdata_i holds the block after cur_q; size_q is the growing size
        if (rdata_i.free) begin
          size_d = size_q + 1'b1 + rdata_i.size;
          if (cur_q + size_d + 1'b1 >= arena_i) state_d = S_DONE;
          else begin
            cmd_o.re = 1'b1;
            cmd_o.raddr = GW'(cur_q + size_d + 1'b1);
            state_d = S_MREAD;
          end
        end else state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
        if (status_q == ffba_pkg::ST_DONE && req_q.kind != ffba_pkg::KIND_QUERY) begin
          cmd_o.we = 1'b1;
          cmd_o.waddr = GW'(cur_q);
          cmd_o.wdata = '{free: (req_q.kind == ffba_pkg::KIND_FREE), size: size_q};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.status = status_q;
    rsp_o.granted_offset = grant_q;
    rsp_o.bytes_in_use = inuse_q;
    rsp_o.high_water_bytes = peak_q;
    rsp_o.failure_count = fail_q;
    rsp_o.largest_free_bytes = 15'({best_q, 3'b000});
  end
  logic unused;
  assign unused = ^{dec, inc[16]};
endmodule
`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an arena of 8-byte granules with coalescing free.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o low; its result shows
// for one cycle with done_o and cannot be held off. Each request walks the
// block chain one header at a time through the header memory, reading a
// header in S_READ and testing it in S_EVAL, and the next request can be
// taken in the cycle the result shows; a free also merges each free block
// that follows it. After reset or an arena write busy_o is high for one
// cycle while the single arena header is written.
`default_nettype none
module first_fit_block_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire ffba_pkg::req_t req_i,
  output logic                busy_o,
  output logic                done_o,
  output ffba_pkg::rsp_t      rsp_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [ffba_pkg::SW-1:0] arena_q;
  logic wr;
  logic [12:0] v;
  ffba_pkg::mem_cmd_t cmd;
  ffba_pkg::hdr_t rdata;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && paddr[2] == ffba_pkg::REG_ARENA && paddr[1:0] == 2'd0;
  assign v = pwdata[12:0];
  assign prdata = (paddr[2] == ffba_pkg::REG_ARENA) ? 32'(arena_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) arena_q <= ffba_pkg::SW'(ffba_pkg::ArenaGranules);
    else if (wr) begin
      if (v < 13'd2) arena_q <= ffba_pkg::SW'(2);
      else if (32'(v) > ffba_pkg::ArenaGranules)
        arena_q <= ffba_pkg::SW'(ffba_pkg::ArenaGranules);
      else arena_q <= ffba_pkg::SW'(v);
    end
  end

  ffba_walker u_walk (
    .clk_i, .rst_ni, .start_i, .req_i, .carve_i(wr), .arena_i(arena_q),
    .busy_o, .valid_o(done_o), .rsp_o, .cmd_o(cmd), .rdata_i(rdata)
  );
  ffba_hdr_ram u_ram (.clk_i, .cmd_i(cmd), .rdata_o(rdata));
endmodule
`default_nettype wire

FILE: hw/rtl/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the allocator.
// ----------------------------------------------------------------------------
`default_nettype none
module ffba_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start_i,
  input wire logic           busy_o,
  input wire logic           done_o,
  input wire ffba_pkg::rsp_t rsp_o
);
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after transfer");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back done");
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.high_water_bytes >= rsp_o.bytes_in_use) else $error("peak below use");
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ffba_pkg::ST_DONE |-> rsp_o.granted_offset == 15'd0)
    else $error("grant on failure");
endmodule
bind first_fit_block_allocator ffba_checker u_chk (.*);
`default_nettype wire
